// File: hdl/taf_pkg.sv
package taf_pkg;

  typedef enum logic [17:0] {
    ST_IDLE          = 18'h00001,
    ST_BEGIN_WAIT    = 18'h00002,
    ST_BEGIN_FAIL    = 18'h00004,
    ST_FETCH_WAIT    = 18'h00008,
    ST_FETCH_FAIL    = 18'h00010,
    ST_FETCH_ERR     = 18'h00020,
    ST_RUNNING       = 18'h00040,
    ST_RUN_FAIL      = 18'h00080,
    ST_RUN_ERR       = 18'h00100,
    ST_COMMIT_WAIT   = 18'h00200,
    ST_COMMIT_FAIL   = 18'h00400,
    ST_COMMIT_ERR    = 18'h00800,
    ST_FINISH_WAIT   = 18'h01000,
    ST_FINISH_FAIL   = 18'h02000,
    ST_DONE          = 18'h04000,
    ST_ROLLBACK_WAIT = 18'h08000,
    ST_ROLLBACK_FAIL = 18'h10000,
    ST_ROLLBACK_DONE = 18'h20000
  } state_e;

  localparam int unsigned NumStates = 18;
  localparam int unsigned MaxRes    = 3;

  typedef enum logic [3:0] {
    REQ_EXEC       = 4'd0,
    REQ_BEGIN_RSP  = 4'd1,
    REQ_FUNC_RSP   = 4'd2,
    REQ_RUN_RESULT = 4'd3,
    REQ_COMMIT_RSP = 4'd4,
    REQ_FINISH_RSP = 4'd5,
    REQ_RB_RSP     = 4'd6,
    REQ_LOCK_REQ   = 4'd7,
    REQ_LOCK_RSP   = 4'd8
  } req_e;

  typedef enum logic [3:0] {
    K_BEGIN    = 4'd0,
    K_FLOCK    = 4'd1,
    K_KLOCK    = 4'd2,
    K_COMMIT   = 4'd3,
    K_FINISH   = 4'd4,
    K_ROLLBACK = 4'd5,
    K_START    = 4'd6,
    K_REPORT   = 4'd7,
    K_ACK      = 4'd8,
    K_REPLY    = 4'd9
  } kind_e;

  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_BROKER = 2'd1;
  localparam logic [1:0] STS_WOUND  = 2'd2;
  localparam logic [1:0] STS_PERM   = 2'd3;

  localparam logic [3:0] RC_SUCCESS     = 4'd0;
  localparam logic [3:0] RC_UNREACHABLE = 4'd1;
  localparam logic [3:0] RC_TICKET      = 4'd2;
  localparam logic [3:0] RC_RETRIEVAL   = 4'd3;
  localparam logic [3:0] RC_EXECUTION   = 4'd4;
  localparam logic [3:0] RC_COMMIT      = 4'd5;
  localparam logic [3:0] RC_FINISH      = 4'd6;
  localparam logic [3:0] RC_ROLLBACK    = 4'd7;
  localparam logic [3:0] RC_RETRY       = 4'd8;

  // configuration register indexes (byte address is 8 * index)
  localparam logic REG_FUNCTION_KEY = 1'b0;
  localparam logic REG_LOCK_WRITE   = 1'b1;

  typedef struct packed {
    req_e        req_type;
    logic [1:0]  status;
    logic [63:0] ticket;
    logic [63:0] key;
    logic [63:0] reply;
    logic        broker_accepts;
    logic        runner_starts;
  } item_t;

  typedef struct packed {
    state_e      state;
    logic [63:0] ticket;
    logic        perm;
    logic [3:0]  result;
  } ctx_t;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] ticket;
    logic [63:0] key;
    logic        lock_write;
    logic [63:0] reply;
    logic [3:0]  code;
    logic        accepted;
    logic [4:0]  state_num;
  } res_t;

  function automatic logic [4:0] st_num(state_e s);
    logic [NumStates-1:0] bits;
    logic [4:0]           v;
    bits = s;
    v    = '0;
    for (int i = 0; i < NumStates; i++) begin
      if (bits[i]) begin
        v = v | 5'(i);
      end
    end
    return v;
  endfunction

endpackage

// File: hdl/taf_cfg.sv
module taf_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output logic [63:0] function_key_o,
  output logic        initial_lock_write_o
);
  import taf_pkg::*;

  logic [63:0] function_key_q;
  logic        lock_write_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      function_key_q <= '0;
      lock_write_q   <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[3])
        REG_FUNCTION_KEY: function_key_q <= pwdata;
        REG_LOCK_WRITE:   lock_write_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_FUNCTION_KEY: prdata = function_key_q;
      REG_LOCK_WRITE:   prdata = {63'd0, lock_write_q};
      default:          prdata = '0;
    endcase
  end

  assign function_key_o       = function_key_q;
  assign initial_lock_write_o = lock_write_q;

endmodule

// File: hdl/taf_step.sv
module taf_step (
  input  taf_pkg::ctx_t  ctx_i,
  input  taf_pkg::item_t item_i,
  input  logic [63:0]    function_key_i,
  input  logic           lock_write_i,
  output taf_pkg::ctx_t  ctx_o,
  output logic [1:0]     cnt_o,
  output taf_pkg::res_t  res_o [taf_pkg::MaxRes]
);
  import taf_pkg::*;

  typedef enum logic [2:0] {
    SND_NONE     = 3'd0,
    SND_BEGIN    = 3'd1,
    SND_FETCH    = 3'd2,
    SND_COMMIT   = 3'd3,
    SND_FINISH   = 3'd4,
    SND_ROLLBACK = 3'd5
  } send_e;

  function automatic res_t mk(kind_e k, logic [63:0] tk, logic [63:0] key, logic lw,
                              logic [63:0] rp, logic [3:0] code, logic acc, state_e s);
    res_t r;
    r.kind       = k;
    r.ticket     = tk;
    r.key        = key;
    r.lock_write = lw;
    r.reply      = rp;
    r.code       = code;
    r.accepted   = acc;
    r.state_num  = st_num(s);
    return r;
  endfunction

  state_e      st;
  state_e      fail_st;
  logic [63:0] tk;
  logic        perm;
  logic [3:0]  rc;
  logic [1:0]  n;
  res_t        r [MaxRes];
  send_e       send;
  logic        snd_perm;
  logic        conc;
  logic        rb;
  logic        rb_perm;
  logic        ok;
  logic        stat_ok;
  logic        stat_perm;

  always_comb begin
    st        = ctx_i.state;
    tk        = ctx_i.ticket;
    perm      = ctx_i.perm;
    rc        = ctx_i.result;
    n         = '0;
    r         = '{default: '0};
    send      = SND_NONE;
    snd_perm  = 1'b0;
    conc      = 1'b0;
    rb        = 1'b0;
    rb_perm   = 1'b0;
    fail_st   = ST_IDLE;
    ok        = item_i.broker_accepts;
    stat_ok   = (item_i.status == STS_OK);
    stat_perm = (item_i.status == STS_PERM);

    // primary reaction to the event
    unique case (item_i.req_type)
      REQ_EXEC: begin
        unique case (st) inside
          ST_IDLE, ST_BEGIN_WAIT, ST_BEGIN_FAIL: begin
            rc   = RC_SUCCESS;
            send = SND_BEGIN;
          end
          ST_ROLLBACK_DONE: begin
            rc   = RC_SUCCESS;
            send = SND_FETCH;
          end
          ST_COMMIT_FAIL, ST_COMMIT_WAIT: send = SND_COMMIT;
          ST_ROLLBACK_FAIL, ST_ROLLBACK_WAIT: begin
            send     = SND_ROLLBACK;
            snd_perm = perm;
          end
          ST_FETCH_WAIT, ST_FETCH_FAIL, ST_RUN_FAIL, ST_RUNNING: send = SND_ROLLBACK;
          ST_FINISH_WAIT, ST_FINISH_FAIL: send = SND_FINISH;
          default: ;
        endcase
      end
      REQ_BEGIN_RSP: begin
        if (st == ST_BEGIN_WAIT) begin
          if (stat_ok) begin
            tk   = item_i.ticket;
            send = SND_FETCH;
          end else begin
            st   = ST_BEGIN_FAIL;
            rc   = RC_TICKET;
            conc = 1'b1;
          end
        end
      end
      REQ_FUNC_RSP: begin
        if (st == ST_FETCH_WAIT) begin
          if (stat_ok) begin
            st = ST_RUNNING;
            r[n] = mk(K_START, '0, function_key_i, 1'b0, '0, '0, 1'b0, st);
            n = n + 2'd1;
            if (!item_i.runner_starts) begin
              st   = ST_RUN_FAIL;
              rc   = RC_EXECUTION;
              conc = 1'b1;
            end
          end else begin
            st   = stat_perm ? ST_FETCH_ERR : ST_FETCH_FAIL;
            rc   = RC_RETRIEVAL;
            conc = 1'b1;
          end
        end
      end
      REQ_RUN_RESULT: begin
        if (st == ST_RUNNING) begin
          if (stat_ok) begin
            rc   = RC_SUCCESS;
            send = SND_COMMIT;
          end else begin
            st   = stat_perm ? ST_RUN_ERR : ST_RUN_FAIL;
            rc   = RC_EXECUTION;
            conc = 1'b1;
          end
        end
      end
      REQ_COMMIT_RSP: begin
        if (st == ST_COMMIT_WAIT) begin
          if (stat_ok) begin
            send = SND_FINISH;
          end else begin
            st   = stat_perm ? ST_COMMIT_ERR : ST_COMMIT_FAIL;
            rc   = RC_COMMIT;
            conc = 1'b1;
          end
        end
      end
      REQ_FINISH_RSP: begin
        if (st == ST_FINISH_WAIT) begin
          if (stat_ok) begin
            st = ST_DONE;
          end else begin
            st = ST_FINISH_FAIL;
            rc = RC_FINISH;
          end
          conc = 1'b1;
        end
      end
      REQ_RB_RSP: begin
        if (st == ST_ROLLBACK_WAIT) begin
          if (!stat_ok) begin
            st   = ST_ROLLBACK_FAIL;
            rc   = RC_ROLLBACK;
            conc = 1'b1;
          end else begin
            st = ST_ROLLBACK_DONE;
            if (perm) begin
              send = SND_FINISH;
            end else begin
              rc   = RC_RETRY;
              conc = 1'b1;
            end
          end
        end
      end
      REQ_LOCK_REQ: begin
        if (st == ST_RUNNING) begin
          r[n] = mk(K_KLOCK, tk, item_i.key, 1'b1, '0, '0, 1'b0, st);
          n = n + 2'd1;
          r[n] = mk(K_ACK, '0, '0, 1'b0, '0, '0, ok, st);
          n = n + 2'd1;
        end else begin
          r[n] = mk(K_ACK, '0, '0, 1'b0, '0, '0, 1'b0, st);
          n = n + 2'd1;
        end
      end
      REQ_LOCK_RSP: begin
        if (st == ST_RUNNING) begin
          r[n] = mk(K_REPLY, '0, '0, 1'b0, item_i.reply, '0, 1'b0, st);
          n = n + 2'd1;
        end
      end
      default: ;
    endcase

    // broker request or runner-independent request, then its refusal path
    if (send != SND_NONE) begin
      unique case (send)
        SND_BEGIN: begin
          st      = ST_BEGIN_WAIT;
          fail_st = ST_BEGIN_FAIL;
          r[n] = mk(K_BEGIN, '0, '0, 1'b0, '0, '0, 1'b0, st);
        end
        SND_FETCH: begin
          st      = ST_FETCH_WAIT;
          fail_st = ST_FETCH_FAIL;
          r[n] = mk(K_FLOCK, tk, function_key_i, lock_write_i, '0, '0, 1'b0, st);
        end
        SND_COMMIT: begin
          st      = ST_COMMIT_WAIT;
          fail_st = ST_COMMIT_FAIL;
          r[n] = mk(K_COMMIT, tk, '0, 1'b0, '0, '0, 1'b0, st);
        end
        SND_FINISH: begin
          st      = ST_FINISH_WAIT;
          fail_st = ST_FINISH_FAIL;
          r[n] = mk(K_FINISH, tk, '0, 1'b0, '0, '0, 1'b0, st);
        end
        SND_ROLLBACK: begin
          st      = ST_ROLLBACK_WAIT;
          fail_st = ST_ROLLBACK_FAIL;
          perm    = snd_perm;
          r[n] = mk(K_ROLLBACK, tk, '0, 1'b0, '0, '0, 1'b0, st);
        end
        default: ;
      endcase
      n = n + 2'd1;
      if (!ok) begin
        st   = fail_st;
        rc   = RC_UNREACHABLE;
        conc = 1'b1;
      end
    end

    // conclude: report, or roll back after a failure
    if (conc) begin
      unique case (st) inside
        ST_BEGIN_FAIL, ST_FINISH_FAIL, ST_ROLLBACK_FAIL, ST_DONE, ST_ROLLBACK_DONE: begin
          r[n] = mk(K_REPORT, '0, '0, 1'b0, '0, rc, 1'b0, st);
          n = n + 2'd1;
        end
        ST_FETCH_FAIL, ST_RUN_FAIL, ST_COMMIT_FAIL: rb = 1'b1;
        ST_FETCH_ERR, ST_RUN_ERR, ST_COMMIT_ERR: begin
          rb      = 1'b1;
          rb_perm = 1'b1;
        end
        default: ;
      endcase
    end

    if (rb) begin
      st   = ST_ROLLBACK_WAIT;
      perm = rb_perm;
      r[n] = mk(K_ROLLBACK, tk, '0, 1'b0, '0, '0, 1'b0, st);
      n = n + 2'd1;
      if (!ok) begin
        st = ST_ROLLBACK_FAIL;
        rc = RC_UNREACHABLE;
        r[n] = mk(K_REPORT, '0, '0, 1'b0, '0, rc, 1'b0, st);
        n = n + 2'd1;
      end
    end

    ctx_o.state  = st;
    ctx_o.ticket = tk;
    ctx_o.perm   = perm;
    ctx_o.result = rc;
    cnt_o        = n;
    res_o        = r;
  end

endmodule

// File: hdl/transaction_agent_fsm_unit.sv
// Transaction agent control: one input item is an event (exec, a broker or
// runner response, or a runner lock request/response) and yields zero to three
// result items. An accepted item sits in an input register; once the result
// buffer is free (or its last result is being taken), the state update and all
// result items of that event are computed combinationally and loaded into a
// three-entry result buffer, while the next item is taken into the input
// register in the same cycle. Results leave the buffer one per cycle while
// out_stall_i is low; events without results pass at one per cycle. An item's
// first result is shown once the item has passed the input register and been
// loaded into the result buffer. Configuration is an APB port with 64-bit
// data: function_key at address 0, initial_lock_write at address 8.
module transaction_agent_fsm_unit (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  req_type_i,
  input  logic [1:0]  event_status_i,
  input  logic [63:0] ticket_in_i,
  input  logic [63:0] key_in_i,
  input  logic [63:0] reply_in_i,
  input  logic        broker_accepts_i,
  input  logic        runner_starts_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  out_kind_o,
  output logic [63:0] ticket_out_o,
  output logic [63:0] key_out_o,
  output logic        lock_is_write_o,
  output logic [63:0] reply_out_o,
  output logic [3:0]  result_code_o,
  output logic        accepted_o,
  output logic [4:0]  agent_state_o,
  output logic        last_o
);
  import taf_pkg::*;

  logic [63:0] function_key;
  logic        lock_write;

  logic        in_vld_q;
  item_t       item_q;
  ctx_t        ctx_q;
  ctx_t        ctx_next;
  logic [1:0]  step_cnt;
  res_t        step_res [MaxRes];

  res_t        buf_q [MaxRes];
  logic [1:0]  buf_cnt_q;
  logic [1:0]  buf_idx_q;
  logic        buf_last;
  logic        out_take;
  logic        advance;
  logic        in_take;
  res_t        cur;

  taf_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .function_key_o       (function_key),
    .initial_lock_write_o (lock_write)
  );

  taf_step u_step (
    .ctx_i          (ctx_q),
    .item_i         (item_q),
    .function_key_i (function_key),
    .lock_write_i   (lock_write),
    .ctx_o          (ctx_next),
    .cnt_o          (step_cnt),
    .res_o          (step_res)
  );

  assign out_valid_o = (buf_cnt_q != 2'd0);
  assign buf_last    = (buf_idx_q == 2'(buf_cnt_q - 2'd1));
  assign out_take    = out_valid_o && !out_stall_i;
  assign advance     = !out_valid_o || (out_take && buf_last);
  assign in_stall_o  = in_vld_q && !advance;
  assign in_take     = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.req_type       <= req_e'(req_type_i);
      item_q.status         <= event_status_i;
      item_q.ticket         <= ticket_in_i;
      item_q.key            <= key_in_i;
      item_q.reply          <= reply_in_i;
      item_q.broker_accepts <= broker_accepts_i;
      item_q.runner_starts  <= runner_starts_i;
    end
  end

  // agent context, committed when the event moves into the result buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q.state  <= ST_IDLE;
      ctx_q.ticket <= '0;
      ctx_q.perm   <= 1'b0;
      ctx_q.result <= RC_SUCCESS;
    end else if (advance && in_vld_q) begin
      ctx_q <= ctx_next;
    end
  end

  // result buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_cnt_q <= '0;
      buf_idx_q <= '0;
    end else if (advance) begin
      buf_cnt_q <= in_vld_q ? step_cnt : 2'd0;
      buf_idx_q <= '0;
    end else if (out_take) begin
      buf_idx_q <= buf_idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_vld_q) begin
      for (int i = 0; i < MaxRes; i++) begin
        buf_q[i] <= step_res[i];
      end
    end
  end

  assign cur = buf_q[buf_idx_q];

  assign out_kind_o      = 4'(cur.kind);
  assign ticket_out_o    = cur.ticket;
  assign key_out_o       = cur.key;
  assign lock_is_write_o = cur.lock_write;
  assign reply_out_o     = cur.reply;
  assign result_code_o   = cur.code;
  assign accepted_o      = cur.accepted;
  assign agent_state_o   = cur.state_num;
  assign last_o          = buf_last;

endmodule
